FILE: design/hsvrgb_pkg.sv
// hsvrgb_pkg: widths, constants and sector codes for the hsv to rgb pixel unit
// no dependencies; used by the channel interfaces and the top level
package hsvrgb_pkg;

    localparam int HUE_W  = 22;
    localparam int CHAN_W = 8;

    // one full turn and one sector in 1/64 degree units
    localparam int HUE_TURN   = 23040;
    localparam int HUE_SECTOR = 3840;

    // whole turns added so any signed hue becomes non-negative
    localparam int HUE_BIAS = HUE_TURN * 92;

    // reciprocal constants for divide by 45 and divide by 15
    localparam int RECIP_45 = 1456;
    localparam int RECIP_15 = 4369;
    localparam int DIV_45   = 45;

    // hue sector: which channel holds max, mid and min
    typedef enum logic [2:0] {
        SEC_RED_GRN  = 3'd0,
        SEC_GRN_RED  = 3'd1,
        SEC_GRN_BLU  = 3'd2,
        SEC_BLU_GRN  = 3'd3,
        SEC_BLU_RED  = 3'd4,
        SEC_RED_BLU  = 3'd5
    } t_sector;

endpackage

FILE: design/hsvrgb_if.sv
// hsvrgb_if: valid/ready channel interfaces for hsva input and rgba output pixels
// depends on hsvrgb_pkg for field widths
interface hsvrgb_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hsvrgb_pkg::HUE_W-1:0]    hue;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   saturation;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   value;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   alpha;

    modport source (output valid, hue, saturation, value, alpha, input ready);
    modport sink   (input valid, hue, saturation, value, alpha, output ready);
endinterface

interface hsvrgb_out_if;
    logic                                   valid;
    logic                                   ready;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   red;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   green;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   blue;
    logic        [hsvrgb_pkg::CHAN_W-1:0]   alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

FILE: design/hsv_to_rgb_pixel_unit.sv
// hsv_to_rgb_pixel_unit: six-stage pipeline; the output comes from the stage 6 registers.
// throughput one pixel per cycle while o_rgb.ready holds: every stage loads while its item moves on.
// each stage holds its item until the next stage frees, so stalls lose nothing.
// synchronous active-low reset clears the stage valid bits only; no other state.
// depends on hsvrgb_pkg and hsvrgb_if
module hsv_to_rgb_pixel_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsvrgb_in_if.sink    i_hsv,
    hsvrgb_out_if.source o_rgb
);
    import hsvrgb_pkg::*;

    localparam int NSTG = 6;

    // stage valid bits and load enables
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG+1:1] en;

    // stage 1: biased hue split, divide-by-45 product, v*s
    logic [22:0] n1_hp;
    logic [23:0] r1_qprod;
    logic [13:0] r1_q;
    logic [8:0]  r1_lo;
    logic [15:0] r1_vs;
    logic [7:0]  r1_v, r1_a;

    // stage 2: reduced hue and chroma
    logic [7:0]  n2_q0;
    logic [13:0] n2_rem;
    logic [5:0]  n2_r45;
    logic [16:0] n2_csum;
    logic [14:0] r2_hu;
    logic [7:0]  r2_chroma, r2_v, r2_a;

    // stage 3: sector, weight, base
    logic [2:0]  n3_cnt;
    logic [14:0] n3_w;
    t_sector     r3_sector;
    logic [11:0] r3_weight;
    logic [7:0]  r3_chroma, r3_base, r3_v, r3_a;

    // stage 4: chroma*weight
    t_sector     r4_sector;
    logic [19:0] r4_cw;
    logic [7:0]  r4_base, r4_v, r4_a;

    // stage 5: divide by 3840 via reciprocal of 15
    logic [12:0] n5_x;
    t_sector     r5_sector;
    logic [24:0] r5_qm;
    logic [7:0]  r5_base, r5_v, r5_a;

    // stage 6: output register
    logic [7:0]  n6_mid;
    logic [7:0]  n6_r, n6_g, n6_b;
    logic [7:0]  r6_r, r6_g, r6_b, r6_a;

    // a stage loads when empty or when its item moves on
    always_comb begin
        en[NSTG+1] = o_rgb.ready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[1] = en[1] ? i_hsv.valid : r_vld[1];
        for (int k = 2; k <= NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    assign i_hsv.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1 next values
    assign n1_hp = 23'({i_hsv.hue[HUE_W-1], i_hsv.hue}) + 23'(HUE_BIAS);

    // stage 2 next values: remainder of q by 45, one correction step
    always_comb begin
        n2_q0   = r1_qprod[23:16];
        n2_rem  = r1_q - 14'(n2_q0) * 14'(DIV_45);
        if (n2_rem >= 14'(DIV_45)) begin
            n2_r45 = 6'(n2_rem - 14'(DIV_45));
        end else begin
            n2_r45 = 6'(n2_rem);
        end
        n2_csum = 17'(r1_vs) + 17'(r1_vs[15:8]) + 17'd1;
    end

    // stage 3 next values: sector by threshold count, mirrored weight
    always_comb begin
        n3_cnt = 3'(r2_hu >= 15'(HUE_SECTOR))     + 3'(r2_hu >= 15'(2 * HUE_SECTOR))
               + 3'(r2_hu >= 15'(3 * HUE_SECTOR)) + 3'(r2_hu >= 15'(4 * HUE_SECTOR))
               + 3'(r2_hu >= 15'(5 * HUE_SECTOR));
        n3_w = r2_hu - 15'(n3_cnt) * 15'(HUE_SECTOR);
        if (n3_cnt[0]) begin
            n3_w = 15'(HUE_SECTOR) - n3_w;
        end
    end

    // stage 5 next value
    assign n5_x = 13'(r4_cw[19:8]) + 13'd1;

    // stage 6: mid level and channel select
    always_comb begin
        n6_mid = r5_base + r5_qm[23:16];
        case (r5_sector)
            SEC_RED_GRN: begin n6_r = r5_v;    n6_g = n6_mid;  n6_b = r5_base; end
            SEC_GRN_RED: begin n6_r = n6_mid;  n6_g = r5_v;    n6_b = r5_base; end
            SEC_GRN_BLU: begin n6_r = r5_base; n6_g = r5_v;    n6_b = n6_mid;  end
            SEC_BLU_GRN: begin n6_r = r5_base; n6_g = n6_mid;  n6_b = r5_v;    end
            SEC_BLU_RED: begin n6_r = n6_mid;  n6_g = r5_base; n6_b = r5_v;    end
            default:     begin n6_r = r5_v;    n6_g = r5_base; n6_b = n6_mid;  end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_qprod <= 24'(n1_hp[22:9]) * 24'(RECIP_45);
            r1_q     <= n1_hp[22:9];
            r1_lo    <= n1_hp[8:0];
            r1_vs    <= 16'(i_hsv.value) * 16'(i_hsv.saturation);
            r1_v     <= i_hsv.value;
            r1_a     <= i_hsv.alpha;
        end
        if (en[2]) begin
            r2_hu     <= {n2_r45, r1_lo};
            r2_chroma <= n2_csum[15:8];
            r2_v      <= r1_v;
            r2_a      <= r1_a;
        end
        if (en[3]) begin
            r3_sector <= t_sector'(n3_cnt);
            r3_weight <= n3_w[11:0];
            r3_chroma <= r2_chroma;
            r3_base   <= r2_v - r2_chroma;
            r3_v      <= r2_v;
            r3_a      <= r2_a;
        end
        if (en[4]) begin
            r4_sector <= r3_sector;
            r4_cw     <= 20'(r3_chroma) * 20'(r3_weight);
            r4_base   <= r3_base;
            r4_v      <= r3_v;
            r4_a      <= r3_a;
        end
        if (en[5]) begin
            r5_sector <= r4_sector;
            r5_qm     <= 25'(n5_x) * 25'(RECIP_15);
            r5_base   <= r4_base;
            r5_v      <= r4_v;
            r5_a      <= r4_a;
        end
        if (en[6]) begin
            r6_r <= n6_r;
            r6_g <= n6_g;
            r6_b <= n6_b;
            r6_a <= r5_a;
        end
    end

    assign o_rgb.valid     = r_vld[NSTG];
    assign o_rgb.red       = r6_r;
    assign o_rgb.green     = r6_g;
    assign o_rgb.blue      = r6_b;
    assign o_rgb.alpha_out = r6_a;

    // reduced hue stays within one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r2_hu < 15'(HUE_TURN)))
        else $error("reduced hue out of range");

    // mirrored weight never exceeds one sector
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_weight <= 12'(HUE_SECTOR)))
        else $error("sector weight out of range");

    // chroma never exceeds value, so base is not wrapped
    a_base_le_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_base <= r3_v))
        else $error("base above value");

    // an empty output stage means the pipeline takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG] |-> i_hsv.ready)
        else $error("input stalled with empty output stage");

endmodule
